/* design/alp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alp_pkg
// Shared types and constants for the address lease pool.
// ----------------------------------------------------------------------------
package alp_pkg;

    localparam int POOL_DEPTH_DEF  = 256;
    localparam int CLIENT_BITS_DEF = 48;

    localparam logic [31:0] OFFER_TICKS         = 32'd30;
    localparam logic [23:0] LEASE_SECONDS_RESET = 24'd60;

    typedef enum logic [1:0] {
        LS_FREE      = 2'd0,
        LS_OFFERED   = 2'd1,
        LS_ALLOCATED = 2'd2
    } lease_state_t;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_DISCOVER = 3'd1,
        CMD_REQUEST  = 3'd2,
        CMD_RELEASE  = 3'd3,
        CMD_RENEW    = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        REG_POOL_BASE     = 2'd0,
        REG_POOL_COUNT    = 2'd1,
        REG_LEASE_SECONDS = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_WALK,
        FSM_RESOLVE,
        FSM_DELIVER
    } fsm_state_t;

endpackage : alp_pkg
`default_nettype wire

/* design/address_lease_pool.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_lease_pool
// Table of address leases held in one RAM; discover, request, release and
// renew walk the table with a read-modify-write sweep.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | command, client_mac, requested_address
//  out     | out_valid / out_stall | status, address
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Tick and unknown commands go from accept to result without a sweep. Discover,
//  request and release sweep the active entries through the RAM read port,
//  one entry a cycle, n = min(pool_count, POOL_DEPTH) entries. Renew reads
//  one entry, and none when the address lies outside the pool. After reset a
//  clearing pass writes every entry, with in_stall high. One item is in
//  work at a time; the output register lets the next item enter while a
//  result waits.
// ----------------------------------------------------------------------------
module address_lease_pool
    import alp_pkg::*;
#(
    parameter int  POOL_DEPTH  = POOL_DEPTH_DEF,
    parameter int  CLIENT_BITS = CLIENT_BITS_DEF,
    localparam int IDX_W       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1),
    localparam int DW          = 2 + CLIENT_BITS + 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [47:0] client_mac,
    input  wire logic [31:0] requested_address,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic [31:0]      address,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // configuration and time
    logic [31:0] pool_base_reg;
    logic [8:0]  pool_count_reg;
    logic [23:0] lease_seconds_reg;
    logic [31:0] now_reg;

    fsm_state_t state_reg, state_next;

    // command in work
    logic [2:0]             cmd_reg;
    logic [CLIENT_BITS-1:0] cli_reg;
    logic [31:0]            req_reg;
    logic                   req_hit_reg;
    logic [IDX_W-1:0]       req_idx_reg;

    // sweep
    logic [CNT_W-1:0] issue_idx_reg;
    logic [CNT_W-1:0] end_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic        res_status_reg;
    logic [31:0] res_addr_reg;
    logic        out_valid_reg;
    logic        status_reg;
    logic [31:0] address_reg;

    // RAM ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [DW-1:0]    ram_wdata;
    logic             ram_re;
    logic [DW-1:0]    ram_rdata;

    logic             in_accept;
    logic             issue;
    logic             walk_done;
    logic             clear_done;
    logic             out_load;

    logic [63:0]            cli_wide;
    logic [CLIENT_BITS-1:0] cli_in;
    logic [CNT_W-1:0]       act_cnt;
    logic [31:0]            req_off;
    logic                   req_hit;
    logic [32:0]            lease_sum;
    logic [32:0]            offer_sum;
    logic [31:0]            lease_exp;
    logic [31:0]            offer_exp;

    // entry in the RAM read register
    logic [1:0]             rd_st;
    logic [CLIENT_BITS-1:0] rd_cl;
    logic [31:0]            rd_ex;
    logic                   rd_held;
    logic                   rd_expired;
    logic                   rd_cl_eq;

    // sweep decisions
    logic pr_write;
    logic [DW-1:0] pr_wdata;
    logic pr_found;
    logic pr_free;

    assign cli_wide = {16'b0, client_mac};
    assign cli_in   = cli_wide[CLIENT_BITS-1:0];

    always_comb
    begin
        if ({23'b0, pool_count_reg} > 32'(POOL_DEPTH))
        begin
            act_cnt = CNT_W'(POOL_DEPTH);
        end
        else
        begin
            act_cnt = CNT_W'(pool_count_reg);
        end
    end

    assign req_off = requested_address - pool_base_reg;
    assign req_hit = req_off < 32'(act_cnt);

    assign lease_sum = {1'b0, now_reg} + {9'b0, lease_seconds_reg};
    assign offer_sum = {1'b0, now_reg} + {1'b0, OFFER_TICKS};
    assign lease_exp = lease_sum[32] ? 32'hFFFF_FFFF : lease_sum[31:0];
    assign offer_exp = offer_sum[32] ? 32'hFFFF_FFFF : offer_sum[31:0];

    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign issue      = (state_reg == FSM_WALK) && (issue_idx_reg != end_reg);
    assign walk_done  = (issue_idx_reg == end_reg) && !pend_reg;
    assign clear_done = clr_idx_reg == IDX_W'(POOL_DEPTH - 1);
    assign out_load   = (state_reg == FSM_DELIVER) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == CMD_DISCOVER || command == CMD_REQUEST ||
                        command == CMD_RELEASE || command == CMD_RENEW)
                    begin
                        state_next = FSM_WALK;
                    end
                    else
                    begin
                        state_next = FSM_RESOLVE;
                    end
                end
            end
            FSM_WALK:
            begin
                if (walk_done)
                begin
                    state_next = FSM_RESOLVE;
                end
            end
            FSM_RESOLVE:
            begin
                state_next = FSM_DELIVER;
            end
            FSM_DELIVER:
            begin
                if (out_load)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Entry processing during the sweep
    // ------------------------------------------------------------------
    assign rd_st      = ram_rdata[DW-1 -: 2];
    assign rd_cl      = ram_rdata[32 +: CLIENT_BITS];
    assign rd_ex      = ram_rdata[31:0];
    assign rd_held    = (rd_st == LS_OFFERED) || (rd_st == LS_ALLOCATED);
    assign rd_expired = rd_held && (rd_ex < now_reg);
    assign rd_cl_eq   = rd_cl == cli_reg;

    always_comb
    begin
        pr_write = 1'b0;
        pr_wdata = '0;
        pr_found = 1'b0;
        pr_free  = 1'b0;
        if (pend_reg)
        begin
            case (cmd_reg)
                CMD_DISCOVER:
                begin
                    // drop stale leases; look at the entry as it stands after that
                    pr_write = rd_expired;
                    pr_found = rd_held && !rd_expired && rd_cl_eq;
                    pr_free  = !rd_held || rd_expired;
                end
                CMD_REQUEST:
                begin
                    if (req_hit_reg && pend_idx_reg == req_idx_reg &&
                        (!rd_held || rd_expired || rd_cl_eq))
                    begin
                        pr_write = 1'b1;
                        pr_wdata = {LS_ALLOCATED, cli_reg, lease_exp};
                        pr_found = 1'b1;
                    end
                    else
                    begin
                        pr_write = rd_expired;
                    end
                end
                CMD_RELEASE:
                begin
                    // first match only
                    if (!found_reg && rd_cl_eq)
                    begin
                        pr_write = 1'b1;
                        pr_found = 1'b1;
                    end
                end
                CMD_RENEW:
                begin
                    if (rd_cl_eq && rd_st == LS_ALLOCATED)
                    begin
                        pr_write = 1'b1;
                        pr_wdata = {LS_ALLOCATED, rd_cl, lease_exp};
                        pr_found = 1'b1;
                    end
                end
                default:
                begin
                    pr_write = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // RAM control; sweep writes trail reads by one entry, so no overlap
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = state_reg != FSM_IDLE;
        ram_re    = issue;
        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_wdata = pr_wdata;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            FSM_WALK:
            begin
                ram_we = pr_write;
            end
            FSM_RESOLVE:
            begin
                // offer a free entry when the client holds none
                if (cmd_reg == CMD_DISCOVER && !found_reg && free_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                    ram_wdata = {LS_OFFERED, cli_reg, offer_exp};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    alp_ram #(
        .WIDTH (DW),
        .DEPTH (POOL_DEPTH)
    ) u_lease_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= FSM_CLEAR;
            clr_idx_reg       <= '0;
            pool_base_reg     <= '0;
            pool_count_reg    <= '0;
            lease_seconds_reg <= LEASE_SECONDS_RESET;
            now_reg           <= '0;
            pend_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == FSM_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POOL_BASE:     pool_base_reg     <= cfg_data;
                    REG_POOL_COUNT:    pool_count_reg    <= cfg_data[8:0];
                    REG_LEASE_SECONDS: lease_seconds_reg <= cfg_data[23:0];
                    default:           pool_base_reg     <= pool_base_reg;
                endcase
            end

            // advance time, saturating
            if (in_accept && command == CMD_TICK && now_reg != 32'hFFFF_FFFF)
            begin
                now_reg <= now_reg + 32'd1;
            end

            pend_reg <= issue;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg        <= command;
            cli_reg        <= cli_in;
            req_reg        <= requested_address;
            req_hit_reg    <= req_hit;
            req_idx_reg    <= req_off[IDX_W-1:0];
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            if (command == CMD_RENEW)
            begin
                issue_idx_reg <= req_hit ? CNT_W'(req_off[IDX_W-1:0]) : '0;
                end_reg       <= req_hit ? CNT_W'(req_off[IDX_W-1:0]) + 1'b1 : '0;
            end
            else
            begin
                issue_idx_reg <= '0;
                end_reg       <= act_cnt;
            end
        end
        else
        begin
            if (issue)
            begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (pr_found && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= pend_idx_reg;
            end
            if (pr_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pend_idx_reg;
            end
        end

        pend_idx_reg <= issue_idx_reg[IDX_W-1:0];

        if (state_reg == FSM_RESOLVE)
        begin
            res_status_reg <= 1'b1;
            res_addr_reg   <= '0;
            case (cmd_reg) inside
                CMD_TICK:
                begin
                    res_status_reg <= 1'b0;
                end
                CMD_DISCOVER:
                begin
                    if (found_reg)
                    begin
                        res_status_reg <= 1'b0;
                        res_addr_reg   <= pool_base_reg + 32'(found_idx_reg);
                    end
                    else if (free_found_reg)
                    begin
                        res_status_reg <= 1'b0;
                        res_addr_reg   <= pool_base_reg + 32'(free_idx_reg);
                    end
                end
                CMD_REQUEST, CMD_RENEW:
                begin
                    if (found_reg)
                    begin
                        res_status_reg <= 1'b0;
                        res_addr_reg   <= req_reg;
                    end
                end
                CMD_RELEASE:
                begin
                    res_status_reg <= !found_reg;
                end
                default:
                begin
                    res_status_reg <= 1'b1;
                end
            endcase
        end

        if (out_load)
        begin
            status_reg  <= res_status_reg;
            address_reg <= res_addr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign address   = address_reg;

endmodule : address_lease_pool
`default_nettype wire

/* design/alp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module alp_ram #(
    parameter int   WIDTH  = 8,
    parameter int   DEPTH  = 16,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : alp_ram
`default_nettype wire

/* bench/tb_address_lease_pool.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_lease_pool
// Drives commands into the lease pool and checks each reply against a
// predictor of the lease table held in the bench. Directed words cover the
// empty pool, address wrap, full pool, expiry, client zero and unknown
// commands. Random phases then run sessions of discover, request, renew and
// release over several pool settings, with random idling on both channels
// and one long output hold.
// ----------------------------------------------------------------------------
module tb_address_lease_pool;
    import alp_pkg::*;

    localparam int     CLK_HALF     = 10;
    localparam int     RESET_CYCLES = 11;
    localparam int     DRAIN_CYCLES = 300;
    localparam int     HOLD_AT      = 150;
    localparam int     HOLD_CYCLES  = 500;
    localparam longint LIMIT_NS     = 64'd50_000_000;

    localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;

    typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [47:0] client_mac;
        logic [31:0] requested_address;
    } lease_word_t;

    typedef struct packed {
        logic        status;
        logic [31:0] address;
    } lease_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = CMD_TICK;
    logic [47:0] client_mac = '0;
    logic [31:0] requested_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [31:0] address;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_POOL_BASE;
    logic [31:0] cfg_data = '0;

    // predicted lease table and settings
    lease_state_t tbl_state  [POOL_DEPTH_DEF];
    logic [47:0]  tbl_client [POOL_DEPTH_DEF];
    logic [31:0]  tbl_expiry [POOL_DEPTH_DEF];
    logic [31:0]  now_ticks;
    logic [31:0]  pool_base_q;
    logic [8:0]   pool_count_q;
    logic [23:0]  lease_len_q;

    lease_word_t  pending_words[$];
    lease_reply_t expected_replies[$];
    lease_word_t  cur_word;
    int           words_sent = 0;
    int           words_taken = 0;
    int           failures = 0;
    int           send_gap_pct = 0;
    int           stall_pct = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;
    logic [47:0]  known_clients [8];

    address_lease_pool i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .client_mac        (client_mac),
        .requested_address (requested_address),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .address           (address),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_lease(int k);
        tbl_state[k]  = LS_FREE;
        tbl_client[k] = '0;
        tbl_expiry[k] = '0;
    endfunction

    function automatic void expire_stale(int n);
        for (int k = 0; k < n; k++)
        begin
            if (tbl_state[k] != LS_FREE && tbl_expiry[k] < now_ticks)
                clear_lease(k);
        end
    endfunction

    // Apply one command to the predicted table and return the reply.
    function automatic lease_reply_t predict_lease(lease_word_t w);
        lease_reply_t r;
        int           n;
        logic         found;
        logic [31:0]  off;
        r.status  = 1'b1;
        r.address = '0;
        found     = 1'b0;
        n   = (pool_count_q > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : int'(pool_count_q);
        off = w.requested_address - pool_base_q;
        case (w.command)
            CMD_TICK:
            begin
                now_ticks = sat_add32(now_ticks, 32'd1);
                r.status  = 1'b0;
            end
            CMD_DISCOVER:
            begin
                expire_stale(n);
                for (int k = 0; k < n && !found; k++)
                begin
                    if (tbl_state[k] != LS_FREE && tbl_client[k] == w.client_mac)
                    begin
                        found     = 1'b1;
                        r.address = pool_base_q + k;
                    end
                end
                for (int k = 0; k < n && !found; k++)
                begin
                    if (tbl_state[k] == LS_FREE)
                    begin
                        found         = 1'b1;
                        tbl_state[k]  = LS_OFFERED;
                        tbl_client[k] = w.client_mac;
                        tbl_expiry[k] = sat_add32(now_ticks, OFFER_TICKS);
                        r.address     = pool_base_q + k;
                    end
                end
                r.status = !found;
            end
            CMD_REQUEST:
            begin
                expire_stale(n);
                if (off < n && (tbl_state[off] == LS_FREE || tbl_client[off] == w.client_mac))
                begin
                    tbl_state[off]  = LS_ALLOCATED;
                    tbl_client[off] = w.client_mac;
                    tbl_expiry[off] = sat_add32(now_ticks, {8'd0, lease_len_q});
                    r.status        = 1'b0;
                    r.address       = w.requested_address;
                end
            end
            CMD_RELEASE:
            begin
                for (int k = 0; k < n && !found; k++)
                begin
                    if (tbl_client[k] == w.client_mac)
                    begin
                        found    = 1'b1;
                        clear_lease(k);
                        r.status = 1'b0;
                    end
                end
            end
            CMD_RENEW:
            begin
                if (off < n && tbl_client[off] == w.client_mac &&
                    tbl_state[off] == LS_ALLOCATED)
                begin
                    tbl_expiry[off] = sat_add32(now_ticks, {8'd0, lease_len_q});
                    r.status        = 1'b0;
                    r.address       = w.requested_address;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // input side: predict at accept, then offer the next word or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_replies.push_back(predict_lease(cur_word));
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    cur_word          = pending_words.pop_front();
                    in_valid          <= 1'b1;
                    command           <= cur_word.command;
                    client_mac        <= cur_word.client_mac;
                    requested_address <= cur_word.requested_address;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side stall, with one long hold to back the pool up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && words_taken >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : reply_check
        lease_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("reply with nothing expected: status %0d address %h", status, address);
                failures++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
                if (address !== want.address)
                begin
                    $error("address: expected %h, got %h", want.address, address);
                    failures++;
                end
            end
        end
    end

    task automatic queue_word(logic [2:0] cmd, logic [47:0] who, logic [31:0] addr);
        lease_word_t w;
        w.command           = cmd;
        w.client_mac        = who;
        w.requested_address = addr;
        pending_words.push_back(w);
        words_sent++;
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    // mostly inside the pool, sometimes just past it or just below it
    function automatic logic [31:0] pick_index(logic [8:0] count);
        if (count == 0)
            return $urandom_range(3);
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? count + $urandom_range(3) : 32'hFFFF_FFFF;
        return $urandom_range(count - 1);
    endfunction

    // end at a clock edge with every accepted word answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(words_taken == words_sent && expected_replies.size() == 0));
    endtask

    task automatic set_pool(logic [31:0] base, logic [8:0] count, logic [23:0] lease);
        cfg_valid <= 1'b1;
        cfg_index <= REG_POOL_BASE;
        cfg_data  <= base;
        do
            @(posedge clk);
        while (!cfg_ready);
        pool_base_q = base;
        cfg_index <= REG_POOL_COUNT;
        cfg_data  <= {23'd0, count};
        do
            @(posedge clk);
        while (!cfg_ready);
        pool_count_q = count;
        cfg_index <= REG_LEASE_SECONDS;
        cfg_data  <= {8'd0, lease};
        do
            @(posedge clk);
        while (!cfg_ready);
        lease_len_q = lease;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [31:0] base, logic [8:0] count, logic [23:0] lease,
                             int items, idle_mode_t mode);
        int          target;
        int          roll;
        logic [47:0] who;
        logic [31:0] addr;
        wait_drained();
        set_pool(base, count, lease);
        case (mode)
            IDLE_RX_HEAVY: begin send_gap_pct = 19; stall_pct = 60; end
            IDLE_TX_HEAVY: begin send_gap_pct = 60; stall_pct = 19; end
            default:       begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
        target = words_sent + items;
        while (words_sent < target)
        begin
            roll = $urandom_range(99);
            who  = known_clients[3'($urandom_range(7))];
            addr = base + pick_index(count);
            if (roll < 60)
            begin
                queue_word(CMD_DISCOVER, who, $urandom);
                queue_word(CMD_REQUEST, who, addr);
                if ($urandom_range(1))
                    queue_word(CMD_RENEW, who, addr);
                repeat ($urandom_range(3))
                    queue_word(CMD_TICK, rand48(), $urandom);
                if ($urandom_range(3) == 0)
                    queue_word(CMD_RELEASE, who, $urandom);
            end
            else if (roll < 80)
                queue_word(CMD_TICK, who, addr);
            else if (roll < 90)
                queue_word(3'($urandom_range(7)), who, addr);
            else
                queue_word(3'($urandom_range(7)), rand48(), $urandom);
        end
    endtask

    initial
    begin
        for (int k = 0; k < POOL_DEPTH_DEF; k++)
            clear_lease(k);
        now_ticks    = '0;
        pool_base_q  = '0;
        pool_count_q = '0;
        lease_len_q  = LEASE_SECONDS_RESET;
        known_clients[0] = '0;
        known_clients[1] = '1;
        for (int k = 2; k < 8; k++)
            known_clients[k] = rand48();
        send_gap_pct = 19;
        stall_pct    = 60;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty pool at reset settings
        queue_word(CMD_DISCOVER, 48'h1, '0);
        queue_word(CMD_RELEASE, '0, '0);
        queue_word(CMD_TICK, '1, '1);
        queue_word(CMD_UNKNOWN_LAST, '1, '1);
        queue_word(CMD_UNKNOWN_FIRST, '0, '0);
        wait_drained();

        // four entries wrapping past the top of the address space, zero lease
        set_pool(32'hFFFF_FFFE, 9'd4, 24'd0);
        queue_word(CMD_DISCOVER, 48'h1, '0);
        queue_word(CMD_DISCOVER, 48'h1, '1);
        queue_word(CMD_DISCOVER, '1, '0);
        queue_word(CMD_DISCOVER, '0, '0);
        queue_word(CMD_DISCOVER, 48'h3, '0);
        queue_word(CMD_DISCOVER, 48'h4, '0);
        queue_word(CMD_REQUEST, 48'h1, 32'hFFFF_FFFE);
        queue_word(CMD_RENEW, 48'h1, 32'hFFFF_FFFE);
        queue_word(CMD_RENEW, '1, 32'hFFFF_FFFF);
        queue_word(CMD_REQUEST, 48'h4, 32'h0000_0002);
        queue_word(CMD_REQUEST, 48'h4, 32'hFFFF_FFFF);
        queue_word(CMD_TICK, '0, '0);
        queue_word(CMD_TICK, '0, '0);
        queue_word(CMD_DISCOVER, 48'h4, '0);
        queue_word(CMD_RELEASE, '1, '0);
        queue_word(CMD_RELEASE, '0, '0);
        queue_word(CMD_RELEASE, 48'h5, '0);
        queue_word(CMD_REQUEST, '0, 32'hFFFF_FFFF);
        queue_word(CMD_RENEW, '0, 32'h0000_0000);

        run_phase($urandom, 9'd16, 24'd20, 180, IDLE_RX_HEAVY);
        run_phase(32'hFFFF_FFFF, 9'd1, 24'd0, 80, IDLE_RX_HEAVY);
        run_phase(32'hFFFF_FFF0, 9'd37, 24'd45, 180, IDLE_RX_HEAVY);
        run_phase($urandom, 9'd256, 24'hFF_FFFF, 60, IDLE_TX_HEAVY);
        run_phase($urandom, 9'd8, 24'd3, 200, IDLE_TX_HEAVY);
        run_phase(32'h8000_0000, 9'd0, 24'd10, 30, IDLE_TX_HEAVY);
        run_phase($urandom, 9'd64, 24'($urandom_range(100, 1)), 200, IDLE_NONE);
        run_phase(32'h0000_0000, 9'd12, 24'd30, 220, IDLE_NONE);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && expected_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/alp_pkg.sv
design/alp_ram.sv
design/address_lease_pool.sv
bench/tb_address_lease_pool.sv
